// ----- rtl/hmbc_pkg.sv -----
// Shared constants and types for the handheld memory map bank controller.
package hmbc_pkg;

  localparam int unsigned BIG_ADDR_W   = 13;  // video, external and work RAM: 8 KiB each
  localparam int unsigned SMALL_ADDR_W = 9;   // sprite, I/O and high RAM share one store
  localparam int unsigned DATA_W       = 8;
  localparam int unsigned BANK_W       = 8;
  localparam int unsigned ROM_OFS_W    = 14;
  localparam int unsigned ROM_ADDR_W   = BANK_W + ROM_OFS_W;
  localparam int unsigned CTRL_W       = 2;

  localparam logic [CTRL_W-1:0] CT_NONE = 2'd0;
  localparam logic [CTRL_W-1:0] CT_MBC1 = 2'd1;
  localparam logic [CTRL_W-1:0] CT_MBC2 = 2'd2;

  localparam logic [3:0]        RAM_EN_KEY   = 4'hA;
  localparam logic [3:0]        RAM_DIS_KEY  = 4'h0;
  localparam logic [BANK_W-1:0] ROM_BANK_RST = 8'd1;

  // Bank controller status toward the access pipeline.
  typedef struct packed {
    logic [BANK_W-1:0] rom_bank;
    logic              ram_en;
    logic              ram_en_next;
  } bank_stat_t;

endpackage

// ----- rtl/handheld_memory_map_bank_controller.sv -----
// Top level: memory map decode, internal RAMs, bank controller and stream ports.
// An accepted access beat passes the access register, then the output register, before
// its result appears on the master side.
// Throughput: one access per cycle while the master side takes results; the registered
// read port of the RAMs sets the two-stage depth.
// Reset: synchronous; then a clearing pass zeroes every entry of all RAMs, with
// s_axis_tready low throughout. Configuration writes are taken during the pass.
module handheld_memory_map_bank_controller
  import hmbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration: controller type (0 none, 1 MBC1, 2 MBC2)
  input  logic              cfg_wr_en,
  input  logic [CTRL_W-1:0] cfg_wr_data,
  // access stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,   // [15:0] address, [23:16] write_data
  input  logic              s_axis_tuser,   // op: 0 read, 1 write
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // [7:0] read_data, [29:8] rom_address,
                                            // [30] ram_enabled, [31] zero
  output logic              m_axis_tuser    // rom_access
);

  // Where the read byte of an access comes from.
  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_VRAM,
    SRC_XRAM,
    SRC_WRAM,
    SRC_SMALL,
    SRC_REG
  } src_t;

  localparam logic [BIG_ADDR_W-1:0]   CLR_LAST = '1;
  localparam logic [15:0]             ADDR_DIV = 16'hFF04;
  localparam logic [15:0]             ADDR_IF  = 16'hFF0F;
  localparam logic [15:0]             ADDR_IE  = 16'hFFFF;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [CTRL_W-1:0] ctrl_type;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_type <= CT_NONE;
    end else if (cfg_wr_en) begin
      ctrl_type <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Input beat fields and address decode
  // ---------------------------------------------------------------------------
  logic              op;
  logic [15:0]       address;
  logic [DATA_W-1:0] wdata;
  logic              in_fire;

  assign op      = s_axis_tuser;
  assign address = s_axis_tdata[15:0];
  assign wdata   = s_axis_tdata[23:16];
  assign in_fire = s_axis_tvalid && s_axis_tready;

  logic hit_vram;
  logic hit_xram;
  logic hit_wram;   // work RAM and its echo
  logic hit_oam;
  logic hit_io;     // whole FF00-FF7F range
  logic hit_hram;
  logic hit_if;
  logic hit_ie;
  logic hit_div;
  logic hit_rom;

  assign hit_rom  = !address[15];
  assign hit_vram = (address[15:13] == 3'b100);
  assign hit_xram = (address[15:13] == 3'b101);
  assign hit_wram = (address[15:13] == 3'b110) ||
                    ((address[15:13] == 3'b111) && (address[15:9] != 7'h7F));
  assign hit_oam  = (address[15:8] == 8'hFE) && (address[7:0] < 8'hA0);
  assign hit_io   = (address[15:8] == 8'hFF) && !address[7];
  assign hit_hram = (address[15:8] == 8'hFF) && address[7] && (address[6:0] != 7'h7F);
  assign hit_if   = (address == ADDR_IF);
  assign hit_ie   = (address == ADDR_IE);
  assign hit_div  = (address == ADDR_DIV);

  // ---------------------------------------------------------------------------
  // Interrupt enable and flag registers
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] int_enable;
  logic [DATA_W-1:0] int_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      int_enable <= '0;
      int_flag   <= '0;
    end else if (in_fire && op) begin
      if (hit_ie) begin
        int_enable <= wdata;
      end
      if (hit_if) begin
        int_flag <= wdata;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Bank controller
  // ---------------------------------------------------------------------------
  bank_stat_t bank_stat;

  hmbc_bank u_bank (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (in_fire && op && hit_rom),
    .address   (address),
    .wr_data   (wdata),
    .ctrl_type (ctrl_type),
    .stat      (bank_stat)
  );

  // ---------------------------------------------------------------------------
  // Clearing pass after reset: zero one entry of every RAM per cycle
  // ---------------------------------------------------------------------------
  logic                  clearing;
  logic [BIG_ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == CLR_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // RAM write and read ports
  // ---------------------------------------------------------------------------
  logic                    wr_fire;
  logic [BIG_ADDR_W-1:0]   big_waddr;
  logic [SMALL_ADDR_W-1:0] small_waddr;
  logic [DATA_W-1:0]       ram_wdata;
  logic                    vram_we;
  logic                    xram_we;
  logic                    wram_we;
  logic                    small_we;
  logic [DATA_W-1:0]       vram_rdata;
  logic [DATA_W-1:0]       xram_rdata;
  logic [DATA_W-1:0]       wram_rdata;
  logic [DATA_W-1:0]       small_rdata;

  assign wr_fire     = in_fire && op;
  assign big_waddr   = clearing ? clr_addr : address[BIG_ADDR_W-1:0];
  assign small_waddr = clearing ? clr_addr[SMALL_ADDR_W-1:0] : address[SMALL_ADDR_W-1:0];
  // Divider reset writes zero regardless of the data.
  assign ram_wdata   = (clearing || hit_div) ? '0 : wdata;
  assign vram_we     = clearing || (wr_fire && hit_vram);
  assign xram_we     = clearing || (wr_fire && hit_xram);
  assign wram_we     = clearing || (wr_fire && hit_wram);
  assign small_we    = clearing ||
                       (wr_fire && (hit_oam || hit_hram || (hit_io && !hit_if)));

  hmbc_ram #(.ADDR_W(BIG_ADDR_W), .WIDTH(DATA_W)) u_vram (
    .clk     (clk),
    .wr_en   (vram_we),
    .wr_addr (big_waddr),
    .wr_data (ram_wdata),
    .rd_en   (in_fire),
    .rd_addr (address[BIG_ADDR_W-1:0]),
    .rd_data (vram_rdata)
  );

  hmbc_ram #(.ADDR_W(BIG_ADDR_W), .WIDTH(DATA_W)) u_xram (
    .clk     (clk),
    .wr_en   (xram_we),
    .wr_addr (big_waddr),
    .wr_data (ram_wdata),
    .rd_en   (in_fire),
    .rd_addr (address[BIG_ADDR_W-1:0]),
    .rd_data (xram_rdata)
  );

  hmbc_ram #(.ADDR_W(BIG_ADDR_W), .WIDTH(DATA_W)) u_wram (
    .clk     (clk),
    .wr_en   (wram_we),
    .wr_addr (big_waddr),
    .wr_data (ram_wdata),
    .rd_en   (in_fire),
    .rd_addr (address[BIG_ADDR_W-1:0]),
    .rd_data (wram_rdata)
  );

  // Sprite table at index 000-09F, I/O at 100-17F, high RAM at 180-1FE.
  hmbc_ram #(.ADDR_W(SMALL_ADDR_W), .WIDTH(DATA_W)) u_small (
    .clk     (clk),
    .wr_en   (small_we),
    .wr_addr (small_waddr),
    .wr_data (ram_wdata),
    .rd_en   (in_fire),
    .rd_addr (address[SMALL_ADDR_W-1:0]),
    .rd_data (small_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: access in flight while the RAMs deliver read data
  // ---------------------------------------------------------------------------
  src_t                  src;
  src_t                  s1_src;
  logic [DATA_W-1:0]     reg_byte;
  logic [DATA_W-1:0]     s1_byte;
  logic                  s1_valid;
  logic                  s1_rom;
  logic [ROM_ADDR_W-1:0] s1_rom_addr;
  logic                  s1_ram_en;
  logic [ROM_ADDR_W-1:0] rom_addr;
  logic                  s1_move;

  always_comb begin
    src      = SRC_ZERO;
    reg_byte = '0;
    if (!op && !hit_rom) begin
      if (hit_vram) begin
        src = SRC_VRAM;
      end else if (hit_xram) begin
        src = SRC_XRAM;
      end else if (hit_wram) begin
        src = SRC_WRAM;
      end else if (hit_if) begin
        src      = SRC_REG;
        reg_byte = int_flag;
      end else if (hit_ie) begin
        src      = SRC_REG;
        reg_byte = int_enable;
      end else if (hit_oam || hit_io || hit_hram) begin
        src = SRC_SMALL;
      end
    end
  end

  // Bank 0 passes the address; the switched area lands in the current bank.
  assign rom_addr = address[14] ? {bank_stat.rom_bank, address[ROM_OFS_W-1:0]}
                                : {{BANK_W{1'b0}}, address[ROM_OFS_W-1:0]};

  logic out_valid;

  assign s1_move       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !clearing && (!s1_valid || s1_move);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_src      <= src;
      s1_byte     <= reg_byte;
      s1_rom      <= !op && hit_rom;
      s1_rom_addr <= (!op && hit_rom) ? rom_addr : '0;
      s1_ram_en   <= bank_stat.ram_en_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0]     rd_byte;
  logic [DATA_W-1:0]     out_rdata;
  logic                  out_rom;
  logic [ROM_ADDR_W-1:0] out_rom_addr;
  logic                  out_ram_en;

  always_comb begin
    case (s1_src)
      SRC_VRAM:  rd_byte = vram_rdata;
      SRC_XRAM:  rd_byte = xram_rdata;
      SRC_WRAM:  rd_byte = wram_rdata;
      SRC_SMALL: rd_byte = small_rdata;
      SRC_REG:   rd_byte = s1_byte;
      default:   rd_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_rdata    <= rd_byte;
      out_rom      <= s1_rom;
      out_rom_addr <= s1_rom_addr;
      out_ram_en   <= s1_ram_en;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_ram_en, out_rom_addr, out_rdata};
  assign m_axis_tuser  = out_rom;

endmodule

// ----- rtl/hmbc_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
module hmbc_ram
  import hmbc_pkg::*;
#(
  parameter int unsigned ADDR_W = BIG_ADDR_W,
  parameter int unsigned WIDTH  = DATA_W
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/hmbc_bank.sv -----
// Cartridge bank controller: RAM enable flag and switched ROM bank number.
module hmbc_bank
  import hmbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,      // accepted write below 8000
  input  logic [15:0]       address,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [CTRL_W-1:0] ctrl_type,
  output bank_stat_t        stat
);

  logic [BANK_W-1:0] rom_bank;
  logic [BANK_W-1:0] rom_bank_next;
  logic              ram_en;
  logic              ram_en_next;
  logic [BANK_W-1:0] low_cand;
  logic [BANK_W-1:0] high_cand;
  logic              is_mbc1;
  logic              is_mbc2;

  assign is_mbc1   = (ctrl_type == CT_MBC1);
  assign is_mbc2   = (ctrl_type == CT_MBC2);
  assign low_cand  = is_mbc2 ? {4'b0, wr_data[3:0]} : {rom_bank[7:5], wr_data[4:0]};
  assign high_cand = {wr_data[7:5], rom_bank[4:0]};

  always_comb begin
    rom_bank_next = rom_bank;
    ram_en_next   = ram_en;
    if (wr_en && (is_mbc1 || is_mbc2)) begin
      case (address[14:13])
        2'b00: begin
          // MBC2 ignores enable writes with address bit 4 set.
          if (!(is_mbc2 && address[4])) begin
            if (wr_data[3:0] == RAM_EN_KEY) begin
              ram_en_next = 1'b1;
            end else if (wr_data[3:0] == RAM_DIS_KEY) begin
              ram_en_next = 1'b0;
            end
          end
        end
        2'b01: begin
          rom_bank_next = (low_cand == '0) ? ROM_BANK_RST : low_cand;
        end
        2'b10: begin
          if (is_mbc1) begin
            rom_bank_next = (high_cand == '0) ? ROM_BANK_RST : high_cand;
          end
        end
        default: begin
          // mode area: drop the write
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank <= ROM_BANK_RST;
      ram_en   <= 1'b0;
    end else begin
      rom_bank <= rom_bank_next;
      ram_en   <= ram_en_next;
    end
  end

  assign stat.rom_bank    = rom_bank;
  assign stat.ram_en      = ram_en;
  assign stat.ram_en_next = ram_en_next;

endmodule
